### hdl/mpip_pkg.sv
// Shared types, constants and helpers of the multi-ring point-in-polygon core.
`default_nettype none
package mpip_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_RINGS    = 16;
	localparam int MIN_RING_LEN = 3;

	localparam int VADDR_W = $clog2(MAX_VERTICES);
	localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int RIDX_W  = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
	localparam int RCNT_W  = $clog2(MAX_RINGS + 1);

	localparam int DIV_STEPS = 64;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_OPEN   = 2'd1;
	localparam logic [1:0] CMD_APPEND = 2'd2;
	localparam logic [1:0] CMD_QUERY  = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} cmd_t;

	typedef struct packed {
		logic inside_res;
		logic overflowed;
	} res_t;

	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] x;
	} vtx_t;

	typedef struct packed {
		logic [VADDR_W-1:0] start;
		logic [VCNT_W-1:0]  len;
		logic signed [31:0] xlo;
		logic signed [31:0] xhi;
		logic signed [31:0] ylo;
		logic signed [31:0] yhi;
	} ring_ent_t;

	typedef struct packed {
		logic go;
		vtx_t a;
		vtx_t b;
		vtx_t p;
	} cross_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} cross_rsp_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_MUL,
		C_DIV,
		C_CMP,
		C_DONE
	} cross_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RING_RD,
		S_RING_CHK,
		S_VTX_RD,
		S_VTX_CHK,
		S_CROSS,
		S_CLOSE,
		S_CLOSE_WAIT,
		S_RESULT
	} query_state_t;

	// Magnitude of a 33-bit signed difference of two 32-bit coordinates
	function automatic logic [31:0] mag32(input logic signed [32:0] v);
		logic [32:0] n;
		begin
			n = -v;
			mag32 = v[32] ? n[31:0] : v[31:0];
		end
	endfunction

endpackage
`default_nettype wire

### hdl/mpip_cross.sv
// Edge crossing test: multiply, 64-step restoring divide, signed compare.
`default_nettype none
module mpip_cross import mpip_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cross_req_t req,
	output cross_rsp_t      rsp
);

	cross_state_t state_q, state_d;

	logic signed [32:0] dx, dy, den;
	logic               straddle;

	logic               straddle_q;
	logic               neg_q;
	logic [31:0]        mdx_q, mdy_q, mden_q;
	logic signed [31:0] ax_q, px_q;
	logic [63:0]        quo_q;
	logic [31:0]        rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               hit_q;

	logic [32:0]        rem_sh;
	logic               fits;
	logic signed [65:0] qs, sum;

	// Edge geometry from the request
	always_comb begin
		dx       = {req.b.x[31], req.b.x} - {req.a.x[31], req.a.x};
		dy       = {req.p.y[31], req.p.y} - {req.a.y[31], req.a.y};
		den      = {req.b.y[31], req.b.y} - {req.a.y[31], req.a.y};
		straddle = (req.a.y > req.p.y) != (req.b.y > req.p.y);
	end

	// Divider step and final compare
	always_comb begin
		rem_sh = {rem_q, quo_q[63]};
		fits   = rem_sh >= {1'b0, mden_q};
		qs     = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
		sum    = qs + {{34{ax_q[31]}}, ax_q};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: if (req.go) state_d = C_MUL;
			C_MUL:  state_d = straddle_q ? C_DIV : C_DONE;
			C_DIV:  if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = C_CMP;
			C_CMP:  state_d = C_DONE;
			C_DONE: state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		rsp.done = (state_q == C_DONE);
		rsp.hit  = hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				straddle_q <= straddle;
				neg_q      <= (dx[32] != dy[32]) != den[32];
				mdx_q      <= mag32(dx);
				mdy_q      <= mag32(dy);
				mden_q     <= mag32(den);
				ax_q       <= req.a.x;
				px_q       <= req.p.x;
			end
			C_MUL: begin
				quo_q  <= mdx_q * mdy_q;
				rem_q  <= '0;
				step_q <= '0;
				hit_q  <= 1'b0;
			end
			C_DIV: begin
				if (fits) begin
					rem_q <= 32'(rem_sh - {1'b0, mden_q});
				end else begin
					rem_q <= rem_sh[31:0];
				end
				quo_q  <= {quo_q[62:0], fits};
				step_q <= step_q + 1'b1;
			end
			C_CMP: hit_q <= $signed({{34{px_q[31]}}, px_q}) < sum;
			default: ;
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("crossing done longer than one cycle");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_DIV) |-> (rem_q < mden_q)) else $error("divider remainder out of range");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> (state_q == C_IDLE)) else $error("crossing request while busy");

endmodule
`default_nettype wire

### hdl/multi_ring_point_in_polygon_core.sv
// Multi-ring point-in-polygon core: vertex and ring memories, query sequencer.
// Clear, open and append leave the sequencer idle; busy stays low and a new command
// may follow in the next cycle. A query outside the overall box goes straight to
// the result state; otherwise the sequencer reads each ring entry and, for a ring
// whose box holds the point, walks its vertices and edges through the crossing test.
// The result strobe done is high one cycle at the end of a query. Reset clears
// the counts, the open ring and the overflow flag; memories are not cleared.
`default_nettype none
module multi_ring_point_in_polygon_core import mpip_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output res_t      res
);

	query_state_t state_q, state_d;

	// Memories
	vtx_t      vmem [MAX_VERTICES];
	ring_ent_t rmem [MAX_RINGS];
	vtx_t      vrd_q;
	ring_ent_t rrd_q;

	// Store control
	logic [VCNT_W-1:0]  vcnt_q;
	logic [RCNT_W-1:0]  rcnt_q;
	logic               open_q;
	logic               ovf_q;
	logic [VADDR_W-1:0] cur_start_q;
	logic [VCNT_W-1:0]  cur_len_q;
	logic signed [31:0] cur_xlo_q, cur_xhi_q, cur_ylo_q, cur_yhi_q;
	logic               outer_q;
	logic signed [31:0] oxlo_q, oxhi_q, oylo_q, oyhi_q;

	// Query registers
	vtx_t               p_q;
	logic [RCNT_W-1:0]  r_q;
	logic [VADDR_W-1:0] ring_s_q;
	logic [VCNT_W-1:0]  ring_n_q;
	logic [VCNT_W-1:0]  vidx_q;
	vtx_t               first_q, prev_q;
	logic               odd_q;
	logic               inside_q;

	logic               accept;
	ring_ent_t          new_ent;
	logic signed [31:0] px, py;
	logic [RIDX_W-1:0]  cur_idx;
	logic               outer_ok, ring_ok, vtx_eq, more_rings, more_vtx, closes;
	logic               close_odd;
	logic [VADDR_W-1:0] vaddr;
	cross_req_t         creq;
	cross_rsp_t         crsp;

	// Command decode and append values
	always_comb begin
		accept  = start && (state_q == S_IDLE);
		px      = cmd.point_x;
		py      = cmd.point_y;
		cur_idx = RIDX_W'(rcnt_q - 1'b1);
		new_ent.start = cur_start_q;
		new_ent.len   = cur_len_q + 1'b1;
		if (cur_len_q == '0) begin
			new_ent.xlo = px;
			new_ent.xhi = px;
			new_ent.ylo = py;
			new_ent.yhi = py;
		end else begin
			new_ent.xlo = (px < cur_xlo_q) ? px : cur_xlo_q;
			new_ent.xhi = (px > cur_xhi_q) ? px : cur_xhi_q;
			new_ent.ylo = (py < cur_ylo_q) ? py : cur_ylo_q;
			new_ent.yhi = (py > cur_yhi_q) ? py : cur_yhi_q;
		end
	end

	// Query conditions
	always_comb begin
		outer_ok   = outer_q && (rcnt_q != '0) && px >= oxlo_q && px <= oxhi_q
			&& py >= oylo_q && py <= oyhi_q;
		ring_ok    = (rrd_q.len >= VCNT_W'(MIN_RING_LEN))
			&& p_q.x >= rrd_q.xlo && p_q.x <= rrd_q.xhi
			&& p_q.y >= rrd_q.ylo && p_q.y <= rrd_q.yhi;
		vtx_eq     = (vrd_q == p_q);
		more_rings = ({1'b0, r_q} + 1'b1) < {1'b0, rcnt_q};
		more_vtx   = ({1'b0, vidx_q} + 1'b1) < {1'b0, ring_n_q};
		closes     = (prev_q != first_q);
		close_odd  = odd_q ^ crsp.hit;
		vaddr      = ring_s_q + vidx_q[VADDR_W-1:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:
				if (accept && cmd.command == CMD_QUERY)
					state_d = outer_ok ? S_RING_RD : S_RESULT;
			S_RING_RD:  state_d = S_RING_CHK;
			S_RING_CHK: begin
				if (ring_ok) state_d = S_VTX_RD;
				else state_d = more_rings ? S_RING_RD : S_RESULT;
			end
			S_VTX_RD:   state_d = S_VTX_CHK;
			S_VTX_CHK: begin
				if (vtx_eq) state_d = S_RESULT;
				else if (vidx_q == '0) state_d = S_VTX_RD;
				else state_d = S_CROSS;
			end
			S_CROSS:
				if (crsp.done) state_d = more_vtx ? S_VTX_RD : S_CLOSE;
			S_CLOSE: begin
				if (closes) state_d = S_CLOSE_WAIT;
				else if (odd_q || !more_rings) state_d = S_RESULT;
				else state_d = S_RING_RD;
			end
			S_CLOSE_WAIT:
				if (crsp.done)
					state_d = (close_odd || !more_rings) ? S_RESULT : S_RING_RD;
			S_RESULT:   state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Outputs and crossing requests
	always_comb begin
		busy           = (state_q != S_IDLE);
		done           = (state_q == S_RESULT);
		res.inside_res = inside_q;
		res.overflowed = ovf_q;
		creq.go = ((state_q == S_VTX_CHK) && !vtx_eq && (vidx_q != '0))
			|| ((state_q == S_CLOSE) && closes);
		creq.a  = prev_q;
		creq.b  = (state_q == S_CLOSE) ? first_q : vrd_q;
		creq.p  = p_q;
	end

	mpip_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Store control: counts, open ring and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q  <= '0;
			rcnt_q  <= '0;
			open_q  <= 1'b0;
			ovf_q   <= 1'b0;
			outer_q <= 1'b0;
		end else if (accept) begin
			case (cmd.command)
				CMD_CLEAR: begin
					vcnt_q  <= '0;
					rcnt_q  <= '0;
					open_q  <= 1'b0;
					ovf_q   <= 1'b0;
					outer_q <= 1'b0;
				end
				CMD_OPEN: begin
					if (rcnt_q < RCNT_W'(MAX_RINGS)) begin
						rcnt_q <= rcnt_q + 1'b1;
						open_q <= 1'b1;
					end else begin
						open_q <= 1'b0;
						ovf_q  <= 1'b1;
					end
				end
				CMD_APPEND: begin
					if (!open_q) begin
						if (rcnt_q >= RCNT_W'(MAX_RINGS)) ovf_q <= 1'b1;
					end else if (vcnt_q >= VCNT_W'(MAX_VERTICES)) begin
						ovf_q <= 1'b1;
					end else begin
						vcnt_q  <= vcnt_q + 1'b1;
						outer_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Open ring and overall box registers, memory writes
	always_ff @(posedge clk) begin
		if (accept && cmd.command == CMD_OPEN && rcnt_q < RCNT_W'(MAX_RINGS)) begin
			cur_start_q <= vcnt_q[VADDR_W-1:0];
			cur_len_q   <= '0;
			rmem[rcnt_q[RIDX_W-1:0]] <= '{start: vcnt_q[VADDR_W-1:0], len: '0,
				xlo: '0, xhi: '0, ylo: '0, yhi: '0};
		end
		if (accept && cmd.command == CMD_APPEND && open_q
			&& vcnt_q < VCNT_W'(MAX_VERTICES)) begin
			vmem[vcnt_q[VADDR_W-1:0]] <= '{y: py, x: px};
			rmem[cur_idx] <= new_ent;
			cur_len_q <= new_ent.len;
			cur_xlo_q <= new_ent.xlo;
			cur_xhi_q <= new_ent.xhi;
			cur_ylo_q <= new_ent.ylo;
			cur_yhi_q <= new_ent.yhi;
			if (!outer_q) begin
				oxlo_q <= px;
				oxhi_q <= px;
				oylo_q <= py;
				oyhi_q <= py;
			end else begin
				if (px < oxlo_q) oxlo_q <= px;
				if (px > oxhi_q) oxhi_q <= px;
				if (py < oylo_q) oylo_q <= py;
				if (py > oyhi_q) oyhi_q <= py;
			end
		end
	end

	// Memory reads
	always_ff @(posedge clk) begin
		if (state_q == S_RING_RD) rrd_q <= rmem[r_q[RIDX_W-1:0]];
		if (state_q == S_VTX_RD)  vrd_q <= vmem[vaddr];
	end

	// Query walk
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				p_q      <= '{y: py, x: px};
				r_q      <= '0;
				inside_q <= 1'b0;
			end
			S_RING_CHK: begin
				ring_s_q <= rrd_q.start;
				ring_n_q <= rrd_q.len;
				vidx_q   <= '0;
				odd_q    <= 1'b0;
				if (!ring_ok) r_q <= r_q + 1'b1;
			end
			S_VTX_CHK: begin
				if (vtx_eq) begin
					inside_q <= 1'b1;
				end else if (vidx_q == '0) begin
					first_q <= vrd_q;
					prev_q  <= vrd_q;
					vidx_q  <= vidx_q + 1'b1;
				end
			end
			S_CROSS: begin
				if (crsp.done) begin
					prev_q <= vrd_q;
					odd_q  <= odd_q ^ crsp.hit;
					vidx_q <= vidx_q + 1'b1;
				end
			end
			S_CLOSE: begin
				if (!closes) begin
					if (odd_q) inside_q <= 1'b1;
					else r_q <= r_q + 1'b1;
				end
			end
			S_CLOSE_WAIT: begin
				if (crsp.done) begin
					if (close_odd) inside_q <= 1'b1;
					else r_q <= r_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a query");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy) else $error("result strobe not a single cycle");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.command == CMD_QUERY) |=> busy)
		else $error("query transaction not started");
	a_vcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= VCNT_W'(MAX_VERTICES)) else $error("vertex count past store size");
	a_rcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RCNT_W'(MAX_RINGS)) else $error("ring count past table size");

endmodule
`default_nettype wire

### tb/tb_multi_ring_point_in_polygon_core.sv
// Self-checking testbench of the multi-ring point-in-polygon core.
`default_nettype none
module tb_multi_ring_point_in_polygon_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mpip_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 580;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	res_t res;

	multi_ring_point_in_polygon_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .res(res)
	);

	// Golden copy of the polygon store
	logic signed [31:0] vx_mem [MAX_VERTICES];
	logic signed [31:0] vy_mem [MAX_VERTICES];
	int unsigned        n_verts;
	int unsigned        n_rings;
	int unsigned        ring_base [MAX_RINGS];
	int unsigned        ring_len  [MAX_RINGS];
	logic signed [31:0] rxlo [MAX_RINGS], rxhi [MAX_RINGS];
	logic signed [31:0] rylo [MAX_RINGS], ryhi [MAX_RINGS];
	logic signed [31:0] oxlo, oxhi, oylo, oyhi;
	bit                 outer_ok;
	bit                 ring_live;
	bit                 sticky_ovf;

	cmd_t pending_q [$];
	res_t answer_q [$];
	int   errors;
	int   gap;
	int   burst_left;
	bit   no_idle;
	longint cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(input string what);
		errors++;
		$display("ERROR @%0t: %s", $realtime, what);
	endtask

	// Edge test: does the horizontal ray from p to the right cross edge a-b
	function automatic bit ray_hits(input longint ax, input longint ay, input longint bx,
			input longint by, input longint px, input longint py);
		longint dx, dy, den, q;
		longint unsigned mag;
		bit neg;
		if ((ay > py) == (by > py))
			return 1'b0;
		dx = bx - ax;
		dy = py - ay;
		den = by - ay;
		neg = ((dx < 0) != (dy < 0)) != (den < 0);
		mag = (longint'(dx < 0 ? -dx : dx) * longint'(dy < 0 ? -dy : dy));
		mag = longint'(unsigned'(mag) / unsigned'(longint'(den < 0 ? -den : den)));
		q = neg ? -longint'(mag) : longint'(mag);
		return px < q + ax;
	endfunction

	function automatic bit ring_contains(input int r, input longint px, input longint py);
		int unsigned s, n, i;
		bit odd;
		s = ring_base[r];
		n = ring_len[r];
		odd = 1'b0;
		for (i = 0; i < n; i++)
			if (vx_mem[s+i] == px && vy_mem[s+i] == py)
				return 1'b1;
		for (i = 0; i + 1 < n; i++)
			if (ray_hits(vx_mem[s+i], vy_mem[s+i], vx_mem[s+i+1], vy_mem[s+i+1], px, py))
				odd = !odd;
		if ((vx_mem[s] != vx_mem[s+n-1] || vy_mem[s] != vy_mem[s+n-1]) &&
				ray_hits(vx_mem[s+n-1], vy_mem[s+n-1], vx_mem[s], vy_mem[s], px, py))
			odd = !odd;
		return odd;
	endfunction

	// Advance the golden store by one accepted transaction
	task automatic apply_command(input cmd_t c);
		res_t r;
		int unsigned cur;
		int k;
		logic signed [31:0] px, py;
		px = c.point_x;
		py = c.point_y;
		case (c.command)
			CMD_CLEAR: begin
				n_verts = 0;
				n_rings = 0;
				ring_live = 1'b0;
				outer_ok = 1'b0;
				sticky_ovf = 1'b0;
			end
			CMD_OPEN: begin
				if (n_rings < MAX_RINGS) begin
					ring_base[n_rings] = n_verts;
					ring_len[n_rings] = 0;
					n_rings++;
					ring_live = 1'b1;
				end else begin
					ring_live = 1'b0;
					sticky_ovf = 1'b1;
				end
			end
			CMD_APPEND: begin
				if (!ring_live) begin
					if (n_rings >= MAX_RINGS)
						sticky_ovf = 1'b1;
				end else if (n_verts >= MAX_VERTICES) begin
					sticky_ovf = 1'b1;
				end else begin
					cur = n_rings - 1;
					vx_mem[n_verts] = px;
					vy_mem[n_verts] = py;
					n_verts++;
					if (ring_len[cur] == 0) begin
						rxlo[cur] = px; rxhi[cur] = px;
						rylo[cur] = py; ryhi[cur] = py;
					end else begin
						if (px < rxlo[cur]) rxlo[cur] = px;
						if (px > rxhi[cur]) rxhi[cur] = px;
						if (py < rylo[cur]) rylo[cur] = py;
						if (py > ryhi[cur]) ryhi[cur] = py;
					end
					ring_len[cur]++;
					if (!outer_ok) begin
						oxlo = px; oxhi = px; oylo = py; oyhi = py;
						outer_ok = 1'b1;
					end else begin
						if (px < oxlo) oxlo = px;
						if (px > oxhi) oxhi = px;
						if (py < oylo) oylo = py;
						if (py > oyhi) oyhi = py;
					end
				end
			end
			default: begin
				r.inside_res = 1'b0;
				r.overflowed = sticky_ovf;
				if (outer_ok && px >= oxlo && px <= oxhi && py >= oylo && py <= oyhi)
					for (k = 0; k < n_rings && !r.inside_res; k++)
						if (ring_len[k] >= MIN_RING_LEN && px >= rxlo[k] && px <= rxhi[k] &&
								py >= rylo[k] && py <= ryhi[k] && ring_contains(k, px, py))
							r.inside_res = 1'b1;
				answer_q.push_back(r);
			end
		endcase
	endtask

	task automatic add_item(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y);
		cmd_t c;
		c.command = op;
		c.point_x = x;
		c.point_y = y;
		pending_q.push_back(c);
	endtask

	// Driver: present one transaction at a time, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap <= 0;
			burst_left <= 40;
			no_idle <= 1'b0;
		end else begin
			automatic bit taken = start && !busy;
			automatic int g = gap;
			if (taken) begin
				apply_command(cmd);
				g = no_idle ? 0 : $urandom_range(0, 17);
				if (burst_left == 0) begin
					no_idle <= !no_idle;
					burst_left <= $urandom_range(10, 60);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
			if (start && !taken) begin
				start <= 1'b1;
			end else if (g > 0) begin
				start <= 1'b0;
				gap <= g - 1;
			end else if (pending_q.size() != 0) begin
				cmd <= pending_q.pop_front();
				start <= 1'b1;
				gap <= 0;
			end else begin
				start <= 1'b0;
				gap <= 0;
			end
		end
	end

	// Monitor: check each result strobe against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				report("result with no query waiting");
			end else begin
				automatic res_t w = answer_q.pop_front();
				if (res.inside_res !== w.inside_res)
					report($sformatf("inside_res %b, want %b", res.inside_res, w.inside_res));
				if (res.overflowed !== w.overflowed)
					report($sformatf("overflowed %b, want %b", res.overflowed, w.overflowed));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [31:0] pick_coord(input bit wide, input int center);
		return wide ? $urandom : 32'(center + $urandom_range(0, 40) - 20);
	endfunction

	initial begin
		int nr, nv, nq, k, j, i, made, cx, cy;
		bit wide;
		bit ovf_done;
		logic [31:0] qx, qy;
		logic signed [31:0] seq_x [$];
		logic signed [31:0] seq_y [$];
		arst_n = 1'b0;
		errors = 0;
		cycles = 0;
		n_verts = 0;
		n_rings = 0;
		ring_live = 0;
		outer_ok = 0;
		sticky_ovf = 0;
		ovf_done = 1'b0;

		// Directed: append with no ring, empty store, square, vertex hit,
		// short ring, explicitly closed ring, full-range coordinates
		add_item(CMD_APPEND, 5, 5);
		add_item(CMD_QUERY, 0, 0);
		add_item(CMD_OPEN, 0, 0);
		add_item(CMD_APPEND, 0, 0);
		add_item(CMD_APPEND, 10, 0);
		add_item(CMD_APPEND, 10, 10);
		add_item(CMD_APPEND, 0, 10);
		add_item(CMD_QUERY, 5, 5);
		add_item(CMD_QUERY, 10, 10);
		add_item(CMD_QUERY, 20, 5);
		add_item(CMD_OPEN, 0, 0);
		add_item(CMD_APPEND, 50, 50);
		add_item(CMD_APPEND, 60, 60);
		add_item(CMD_QUERY, 55, 55);
		add_item(CMD_OPEN, 0, 0);
		add_item(CMD_APPEND, 100, 100);
		add_item(CMD_APPEND, 200, 100);
		add_item(CMD_APPEND, 150, 200);
		add_item(CMD_APPEND, 100, 100);
		add_item(CMD_QUERY, 150, 120);
		add_item(CMD_OPEN, 0, 0);
		add_item(CMD_APPEND, 32'h8000_0000, 32'h8000_0000);
		add_item(CMD_APPEND, 32'h7fff_ffff, 32'h8000_0000);
		add_item(CMD_APPEND, 0, 32'h7fff_ffff);
		add_item(CMD_QUERY, 0, 0);
		add_item(CMD_QUERY, 32'h7fff_ffff, 32'h7fff_ffff);

		// Random: ring sets with random content (some rings short), an occasional random command, then queries
		made = 0;
		while (made < RANDOM_ITEMS) begin
			if (!ovf_done && made > 200) begin
				// ring table overflow, then drop appends, then clear
				ovf_done = 1'b1;
				add_item(CMD_CLEAR, $urandom, $urandom);
				for (k = 0; k < MAX_RINGS + 2; k++) begin
					add_item(CMD_OPEN, $urandom, $urandom);
					add_item(CMD_APPEND, k, 0);
				end
				add_item(CMD_QUERY, 0, 0);
				add_item(CMD_CLEAR, 0, 0);
				add_item(CMD_QUERY, 0, 0);
				made += 2 * MAX_RINGS + 8;
			end
			if ($urandom_range(0, 3) != 0) begin
				add_item(CMD_CLEAR, $urandom, $urandom);
				made++;
			end
			seq_x.delete();
			seq_y.delete();
			nr = $urandom_range(1, 4);
			for (k = 0; k < nr; k++) begin
				wide = ($urandom_range(0, 4) == 0);
				cx = $urandom_range(0, 200) - 100;
				cy = $urandom_range(0, 200) - 100;
				add_item(CMD_OPEN, $urandom, $urandom);
				nv = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
				for (j = 0; j < nv; j++) begin
					qx = pick_coord(wide, cx);
					qy = pick_coord(wide, cy);
					seq_x.push_back(qx);
					seq_y.push_back(qy);
					add_item(CMD_APPEND, qx, qy);
				end
				if ($urandom_range(0, 3) == 0) begin
					add_item(CMD_APPEND, seq_x[seq_x.size()-nv], seq_y[seq_y.size()-nv]);
					made++;
				end
				made += nv + 1;
			end
			if ($urandom_range(0, 5) == 0) begin
				add_item(2'($urandom_range(0, 3)), $urandom, $urandom);
				made++;
			end
			nq = $urandom_range(2, 6);
			for (j = 0; j < nq; j++) begin
				i = $urandom_range(0, seq_x.size() - 1);
				case ($urandom_range(0, 3))
					0: begin qx = seq_x[i]; qy = seq_y[i]; end
					1: begin qx = $urandom; qy = $urandom; end
					default: begin
						qx = seq_x[i] + $urandom_range(0, 30) - 15;
						qy = seq_y[i] + $urandom_range(0, 30) - 15;
					end
				endcase
				add_item(CMD_QUERY, qx, qy);
			end
			made += nq;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait until everything is sent and answered
		do @(negedge clk);
		while (pending_q.size() != 0 || answer_q.size() != 0 || start || busy);
		repeat (20) @(posedge clk);
		if (errors == 0 && answer_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
